@@ rtl/dcm_to_unit_quaternion_macros.svh @@
// Assertion macros for the checker file of the DCM to quaternion block.
// No dependencies; include with the bare file name.
`ifndef DCM_TO_UNIT_QUATERNION_MACROS_SVH
`define DCM_TO_UNIT_QUATERNION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCMQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dcmq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dcmq: next-cycle check failed");

`endif

@@ rtl/dcmq_pkg.sv @@
// Shared types and constants of the DCM to quaternion pipeline.
// No dependencies.
`default_nettype none
package dcmq_pkg;

  localparam int NUM_LANES = 4;  // w, x, y, z
  localparam int NUM_ELEMS = 9;  // 3x3 matrix, row major

  // Lane order of the quaternion components.
  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  // Matrix element positions, row major.
  localparam int M00 = 0;
  localparam int M01 = 1;
  localparam int M02 = 2;
  localparam int M10 = 3;
  localparam int M11 = 4;
  localparam int M12 = 5;
  localparam int M20 = 6;
  localparam int M21 = 7;
  localparam int M22 = 8;

  // Pipeline control handed to every stage group.
  typedef struct packed {
    logic en;   // global advance
    logic vld;  // beat entering this group
  } dcmq_ctl_t;

endpackage
`default_nettype wire

@@ rtl/dcmq_front.sv @@
// Pivot selection, component build, sign rectify and magnitude split (2 stages).
// Depends on dcmq_pkg.
`default_nettype none
module dcmq_front import dcmq_pkg::*; #(
  parameter int DW = 32,
  parameter int F  = 30,
  parameter int CW = DW + 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dcmq_ctl_t                           ctl_i,
  input  logic [NUM_ELEMS-1:0][DW-1:0]        mat_i,
  output logic                                vld_o,
  output logic [NUM_LANES-1:0][CW-1:0]        mag_o,
  output logic [NUM_LANES-1:0]                sign_o,
  output logic                                zero_o
);

  logic signed [CW-1:0] e [NUM_ELEMS];
  logic signed [CW-1:0] c_d [NUM_LANES];
  logic signed [CW-1:0] c_q [NUM_LANES];
  logic                 rz_d, rz_q, v1_q;
  logic signed [CW-1:0] one_c, trace, r;

  assign one_c = CW'(1) <<< F;

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_ext
    assign e[k] = {{(CW-DW){mat_i[k][DW-1]}}, mat_i[k]};
  end

  assign trace = e[M00] + e[M11] + e[M22];

  always_comb begin
    if (trace > 0) begin
      r = trace + one_c;
      c_d[LANE_W] = r;
      c_d[LANE_X] = e[M12] - e[M21];
      c_d[LANE_Y] = e[M20] - e[M02];
      c_d[LANE_Z] = e[M01] - e[M10];
    end else if (e[M11] > e[M00] && e[M11] > e[M22]) begin
      r = e[M11] - e[M00] - e[M22] + one_c;
      if (r < 0) r = '0;
      c_d[LANE_Y] = r;
      c_d[LANE_W] = e[M20] - e[M02];
      c_d[LANE_X] = e[M01] + e[M10];
      c_d[LANE_Z] = e[M12] + e[M21];
    end else if (e[M22] > e[M00]) begin
      r = e[M22] - e[M00] - e[M11] + one_c;
      if (r < 0) r = '0;
      c_d[LANE_Z] = r;
      c_d[LANE_W] = e[M01] - e[M10];
      c_d[LANE_X] = e[M20] + e[M02];
      c_d[LANE_Y] = e[M12] + e[M21];
    end else begin
      r = e[M00] - e[M11] - e[M22] + one_c;
      if (r < 0) r = '0;
      c_d[LANE_X] = r;
      c_d[LANE_W] = e[M12] - e[M21];
      c_d[LANE_Y] = e[M01] + e[M10];
      c_d[LANE_Z] = e[M20] + e[M02];
    end
    rz_d = (r == 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q  <= ctl_i.vld;
      vld_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      c_q  <= c_d;
      rz_q <= rz_d;
    end
  end

  // Stage 2: negating all four when w < 0 keeps magnitudes, flips signs.
  logic [NUM_LANES-1:0][CW-1:0] mag_d;
  logic [NUM_LANES-1:0]         sign_d;
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      mag_d[i]  = rz_q ? '0 : (c_q[i] < 0 ? CW'(-c_q[i]) : CW'(c_q[i]));
      sign_d[i] = (c_q[i] < 0) ^ (c_q[LANE_W] < 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      mag_o  <= mag_d;
      sign_o <= sign_d;
      zero_o <= (mag_d == '0);
    end
  end

endmodule
`default_nettype wire

@@ rtl/dcmq_sumsq.sv @@
// Sum of the four squared magnitudes, split multiplies (3 stages).
// Depends on dcmq_pkg.
`default_nettype none
module dcmq_sumsq import dcmq_pkg::*; #(
  parameter int CW     = 34,
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dcmq_ctl_t                    ctl_i,
  input  logic [NUM_LANES-1:0][CW-1:0] mag_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         vld_o,
  output logic [2*CW+1:0]              sum_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int H  = CW / 2;
  localparam int HI = CW - H;

  logic [NUM_LANES-1:0][2*H-1:0]  ll_q;
  logic [NUM_LANES-1:0][H+HI-1:0] lh_q;
  logic [NUM_LANES-1:0][2*HI-1:0] hh_q;
  logic [NUM_LANES-1:0][2*CW-1:0] sq_q;
  logic [SIDE_W-1:0]              s1_q, s2_q;
  logic                           v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q  <= ctl_i.vld;
      v2_q  <= v1_q;
      vld_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        ll_q[i] <= mag_i[i][H-1:0] * mag_i[i][H-1:0];
        lh_q[i] <= mag_i[i][H-1:0] * mag_i[i][CW-1:H];
        hh_q[i] <= mag_i[i][CW-1:H] * mag_i[i][CW-1:H];
        sq_q[i] <= ((2*CW)'(hh_q[i]) << (2*H)) + ((2*CW)'(lh_q[i]) << (H+1))
                   + (2*CW)'(ll_q[i]);
      end
      sum_o  <= (2*CW+2)'(sq_q[0]) + (2*CW+2)'(sq_q[1])
              + (2*CW+2)'(sq_q[2]) + (2*CW+2)'(sq_q[3]);
      s1_q   <= side_i;
      s2_q   <= s1_q;
      side_o <= s2_q;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dcmq_isqrt.sv @@
// Pipelined integer square root, one root bit per stage (NB stages).
// Depends on dcmq_pkg.
`default_nettype none
module dcmq_isqrt import dcmq_pkg::*; #(
  parameter int NB     = 35,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dcmq_ctl_t         ctl_i,
  input  logic [2*NB-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NB-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RW = 2 * NB;

  logic [RW-1:0]     rem_q  [NB];
  logic [NB-1:0]     res_q  [NB];
  logic [SIDE_W-1:0] side_q [NB];
  logic [NB-1:0]     vld_q;

  for (genvar k = 0; k < NB; k++) begin : g_stage
    localparam int B = NB - 1 - k;
    logic [RW-1:0]     rem_p, rem_d, inc;
    logic [NB-1:0]     res_p, res_d;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;

    if (k == 0) begin : g_first
      assign rem_p  = rad_i;
      assign res_p  = '0;
      assign side_p = side_i;
      assign vld_p  = ctl_i.vld;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign res_p  = res_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    // (res + 2^B)^2 - res^2
    assign inc = (RW'(res_p) << (B + 1)) + (RW'(1) << (2 * B));

    always_comb begin
      if (inc <= rem_p) begin
        rem_d = rem_p - inc;
        res_d = res_p | (NB'(1) << B);
      end else begin
        rem_d = rem_p;
        res_d = res_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_q[NB-1];
  assign root_o = res_q[NB-1];
  assign side_o = side_q[NB-1];

endmodule
`default_nettype wire

@@ rtl/dcmq_div.sv @@
// One lane of the rounded normalize divide, restoring, one quotient bit per stage.
// Depends on dcmq_pkg.
`default_nettype none
module dcmq_div import dcmq_pkg::*; #(
  parameter int CW     = 34,
  parameter int NB     = 35,
  parameter int F      = 30,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dcmq_ctl_t         ctl_i,
  input  logic [CW-1:0]     mag_i,
  input  logic [NB-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [F:0]        quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int QB = F + 1;
  localparam int NW = CW + F + 1;

  // Entry stage: numerator with half-divisor rounding term.
  logic [NW-1:0]     num_q;
  logic [NB-1:0]     den0_q;
  logic [SIDE_W-1:0] side0_q;
  logic              vld0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld0_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      num_q   <= (NW'(mag_i) << F) + NW'(den_i >> 1);
      den0_q  <= den_i;
      side0_q <= side_i;
    end
  end

  logic [NB-1:0]     rem_q  [QB];
  logic [QB-1:0]     lo_q   [QB];
  logic [QB-1:0]     quo_q  [QB];
  logic [NB-1:0]     den_q  [QB];
  logic [SIDE_W-1:0] side_q [QB];
  logic [QB-1:0]     vld_q;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NB-1:0]     rem_p, den_p;
    logic [QB-1:0]     lo_p, quo_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [NB:0]       t;

    if (k == 0) begin : g_first
      // Quotient fits QB bits, so the top part is already below the divisor.
      assign rem_p  = NB'(num_q >> QB);
      assign lo_p   = num_q[QB-1:0];
      assign quo_p  = '0;
      assign den_p  = den0_q;
      assign side_p = side0_q;
      assign vld_p  = vld0_q;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign lo_p   = lo_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign t = {rem_p, lo_p[QB-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        if (t >= {1'b0, den_p}) begin
          rem_q[k] <= NB'(t - {1'b0, den_p});
          quo_q[k] <= {quo_p[QB-2:0], 1'b1};
        end else begin
          rem_q[k] <= NB'(t);
          quo_q[k] <= {quo_p[QB-2:0], 1'b0};
        end
        lo_q[k]   <= {lo_p[QB-2:0], 1'b0};
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_q[QB-1];
  assign quo_o  = quo_q[QB-1];
  assign side_o = side_q[QB-1];

endmodule
`default_nettype wire

@@ rtl/dcm_to_unit_quaternion.sv @@
// DCM to unit quaternion, Shepperd pivot selection, fully pipelined.
// Pipeline depth is dominated by the bit-per-stage square root (DATA_WIDTH+3 stages)
// and divider (FRAC_BITS+2).
// Throughput: one matrix per cycle; the whole pipe holds while the output beat waits.
// Reset: rst_ni asynchronous, active low, clears valid bits only.
`default_nettype none
module dcm_to_unit_quaternion import dcmq_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (signed, DATA_WIDTH each)
  input  logic [((NUM_ELEMS*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // quat_w (DATA_WIDTH-1, unsigned), quat_x, quat_y, quat_z (signed)
  output logic [((4*DATA_WIDTH-1+7)/8)*8-1:0]       m_axis_tdata,
  // zero_norm
  output logic [0:0]                                m_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready
);

  localparam int DW     = DATA_WIDTH;
  localparam int CW     = DW + 2;       // component width, carries trace + one
  localparam int NB     = CW + 1;       // root width
  localparam int QB     = FRAC_BITS + 1;
  localparam int OUT_W  = ((4*DW-1+7)/8)*8;
  localparam int SIDE_W = 1 + NUM_LANES + NUM_LANES*CW;  // zero, signs, magnitudes

  // Global advance: every stage moves when the output register is free.
  logic out_v_q, en;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [NUM_ELEMS-1:0][DW-1:0] mat;
  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_unpack
    assign mat[k] = s_axis_tdata[k*DW +: DW];
  end

  // Front: pivot choice, components, rectify.
  logic                         fr_vld, fr_zero;
  logic [NUM_LANES-1:0][CW-1:0] fr_mag;
  logic [NUM_LANES-1:0]         fr_sign;

  dcmq_front #(.DW(DW), .F(FRAC_BITS), .CW(CW)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: s_axis_tvalid}),
    .mat_i  (mat),
    .vld_o  (fr_vld),
    .mag_o  (fr_mag),
    .sign_o (fr_sign),
    .zero_o (fr_zero)
  );

  // Squared norm.
  logic              sq_vld;
  logic [2*CW+1:0]   sq_sum;
  logic [SIDE_W-1:0] sq_side;

  dcmq_sumsq #(.CW(CW), .SIDE_W(SIDE_W)) u_sumsq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: fr_vld}),
    .mag_i  (fr_mag),
    .side_i ({fr_zero, fr_sign, fr_mag}),
    .vld_o  (sq_vld),
    .sum_o  (sq_sum),
    .side_o (sq_side)
  );

  // Norm = floor(sqrt(sum)).
  logic              rt_vld;
  logic [NB-1:0]     rt_root;
  logic [SIDE_W-1:0] rt_side;

  dcmq_isqrt #(.NB(NB), .SIDE_W(SIDE_W)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: sq_vld}),
    .rad_i  (sq_sum),
    .side_i (sq_side),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .side_o (rt_side)
  );

  logic                         rt_zero;
  logic [NUM_LANES-1:0]         rt_sign;
  logic [NUM_LANES-1:0][CW-1:0] rt_mag;
  assign {rt_zero, rt_sign, rt_mag} = rt_side;

  // Four divider lanes; lane w also carries the zero-norm flag.
  // Each |c| <= norm, so quotients never exceed 2^FRAC_BITS.
  logic [NUM_LANES-1:0][FRAC_BITS:0] dv_quo;
  logic [NUM_LANES-1:0]              dv_sign;
  logic                              dv_vld, dv_zero;

  dcmq_div #(.CW(CW), .NB(NB), .F(FRAC_BITS), .SIDE_W(2)) u_div_w (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: rt_vld}),
    .mag_i  (rt_mag[LANE_W]),
    .den_i  (rt_root),
    .side_i ({rt_zero, rt_sign[LANE_W]}),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo[LANE_W]),
    .side_o ({dv_zero, dv_sign[LANE_W]})
  );

  for (genvar l = LANE_X; l <= LANE_Z; l++) begin : g_lane
    dcmq_div #(.CW(CW), .NB(NB), .F(FRAC_BITS), .SIDE_W(1)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  ('{en: en, vld: rt_vld}),
      .mag_i  (rt_mag[l]),
      .den_i  (rt_root),
      .side_i (rt_sign[l]),
      .vld_o  (),
      .quo_o  (dv_quo[l]),
      .side_o (dv_sign[l])
    );
  end

  // Output register: apply signs, force zero on a zero norm.
  logic [NUM_LANES-1:0][DW-1:0] q_s;
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      q_s[i] = dv_sign[i] ? DW'(-DW'(dv_quo[i])) : DW'(dv_quo[i]);
      if (dv_zero) q_s[i] = '0;
    end
  end

  logic [OUT_W-1:0] data_q;
  logic             zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= OUT_W'({q_s[LANE_Z], q_s[LANE_Y], q_s[LANE_X], q_s[LANE_W][DW-2:0]});
      zero_q <= dv_zero;
    end
  end

  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = zero_q;
  assign m_axis_tvalid = out_v_q;

endmodule
`default_nettype wire

@@ rtl/dcmq_chk.sv @@
// Port-level checker for the DCM to quaternion block, bound to the top level.
// Depends on dcm_to_unit_quaternion_macros.svh.
`default_nettype none
`include "dcm_to_unit_quaternion_macros.svh"
module dcmq_chk #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 30
) (
  input logic clk_i,
  input logic rst_ni,
  input logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [((4*DATA_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
  input logic [0:0]                        m_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);

  localparam logic [DATA_WIDTH-2:0] ONE = (DATA_WIDTH-1)'(1) << FRAC_BITS;

  // Held output beat stays offered.
  `DCMQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // Input side only stalls behind a blocked output beat.
  `DCMQ_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // Zero-norm beats carry an all-zero quaternion.
  `DCMQ_ASSERT_IMPL(a_zero_data, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  // Scalar part never exceeds one.
  `DCMQ_ASSERT_IMPL(a_w_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[DATA_WIDTH-2:0] <= ONE)

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tvalid};

endmodule

bind dcm_to_unit_quaternion dcmq_chk #(
  .DATA_WIDTH (DATA_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_dcm_to_unit_quaternion.sv @@
// Testbench for dcm_to_unit_quaternion: directed matrices, then random ones,
// each result checked against a behavioral model of Shepperd's method.
// Depends on dcmq_pkg and the dcm_to_unit_quaternion RTL.
`timescale 1ns / 1ps
module tb_dcm_to_unit_quaternion;
  import dcmq_pkg::*;

  localparam int DW = 32;
  localparam int FB = 30;
  localparam int IN_W = ((NUM_ELEMS*DW+7)/8)*8;   // 288
  localparam int OUT_W = ((4*DW-1+7)/8)*8;        // 128
  localparam longint ONE = 64'sd1 << FB;
  localparam logic [31:0] P1 = 32'h4000_0000;     // +1.0
  localparam logic [31:0] N1 = 32'hC000_0000;     // -1.0
  localparam logic [31:0] MX = 32'h7FFF_FFFF;
  localparam logic [31:0] MN = 32'h8000_0000;

  typedef logic [31:0] mat_t [NUM_ELEMS];
  typedef struct packed {
    logic [30:0] w;
    logic [31:0] x, y, z;
    logic        zn;
  } quat_t;

  logic clk_i = 0, rst_ni = 0;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic m_axis_tvalid, m_axis_tready = 0;

  dcm_to_unit_quaternion u_dut (.*);

  always #5 clk_i = ~clk_i;

  quat_t quat_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;  // percent of cycles each side idles

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic quat_t predict_quat(input mat_t m);
    longint e[NUM_ELEMS], c[4], r, tr;
    logic [127:0] s, t, num;
    logic [63:0] n, q;
    quat_t res;
    for (int i = 0; i < NUM_ELEMS; i++) e[i] = longint'(signed'(m[i]));
    tr = e[M00] + e[M11] + e[M22];
    if (tr > 0) begin
      r = tr + ONE;
      c[0] = r; c[1] = e[M12]-e[M21]; c[2] = e[M20]-e[M02]; c[3] = e[M01]-e[M10];
    end else if (e[M11] > e[M00] && e[M11] > e[M22]) begin
      r = e[M11] - e[M00] - e[M22] + ONE; if (r < 0) r = 0;
      c[2] = r; c[0] = e[M20]-e[M02]; c[1] = e[M01]+e[M10]; c[3] = e[M12]+e[M21];
    end else if (e[M22] > e[M00]) begin
      r = e[M22] - e[M00] - e[M11] + ONE; if (r < 0) r = 0;
      c[3] = r; c[0] = e[M01]-e[M10]; c[1] = e[M20]+e[M02]; c[2] = e[M12]+e[M21];
    end else begin
      r = e[M00] - e[M11] - e[M22] + ONE; if (r < 0) r = 0;
      c[1] = r; c[0] = e[M12]-e[M21]; c[2] = e[M01]+e[M10]; c[3] = e[M20]+e[M02];
    end
    if (r == 0) c = '{0, 0, 0, 0};
    if (c[0] < 0) for (int i = 0; i < 4; i++) c[i] = -c[i];
    s = '0;
    for (int i = 0; i < 4; i++) begin
      t = 128'(c[i] < 0 ? -c[i] : c[i]);
      s += t * t;
    end
    res = '0;
    if (s == 0) begin
      res.zn = 1'b1;
      return res;
    end
    // bitwise integer square root, result below 2^41
    n = '0;
    for (int b = 40; b >= 0; b--) begin
      t = 128'(n | (64'd1 << b));
      if (t * t <= s) n = n | (64'd1 << b);
    end
    for (int i = 0; i < 4; i++) begin
      num = (128'(c[i] < 0 ? -c[i] : c[i]) << FB) + 128'(n >> 1);
      q = 64'(num / 128'(n));
      if (q > 64'(ONE)) q = 64'(ONE);
      if (c[i] < 0) q = -q;
      case (i)
        LANE_W: res.w = q[30:0];
        LANE_X: res.x = q[31:0];
        LANE_Y: res.y = q[31:0];
        default: res.z = q[31:0];
      endcase
    end
    return res;
  endfunction

  // Hold the beat until accepted; valid stays high across back-to-back beats.
  task automatic send_matrix(input mat_t m, input logic chk, input quat_t want);
    logic [IN_W-1:0] d;
    quat_t p;
    d = '0;
    for (int i = 0; i < NUM_ELEMS; i++) d[i*DW +: DW] = m[i];
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = predict_quat(m);
    if (chk && p !== want) report("model disagrees with typed-in value");
    quat_q.push_back(chk ? want : p);
  endtask

  // Receiver: random backpressure, compare each beat with the oldest expectation.
  always @(posedge clk_i) begin
    quat_t got, exp_q;
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[30:0], m_axis_tdata[62:31], m_axis_tdata[94:63],
             m_axis_tdata[126:95], m_axis_tuser[0]};
      if (quat_q.size() == 0) report("result beat with nothing expected");
      else begin
        exp_q = quat_q.pop_front();
        if (got.w !== exp_q.w) report($sformatf("w %h exp %h", got.w, exp_q.w));
        if (got.x !== exp_q.x) report($sformatf("x %h exp %h", got.x, exp_q.x));
        if (got.y !== exp_q.y) report($sformatf("y %h exp %h", got.y, exp_q.y));
        if (got.z !== exp_q.z) report($sformatf("z %h exp %h", got.z, exp_q.z));
        if (got.zn !== exp_q.zn) report($sformatf("zero_norm %b exp %b", got.zn, exp_q.zn));
      end
    end
  end

  typedef struct {
    mat_t  m;
    logic  chk;
    quat_t want;
  } dir_row_t;

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($urandom_range(2*(1<<30))) - P1;  // within +-1.0
      2: return {{2{1'b0}}, 30'($urandom())} ^ {32{$urandom_range(1)==1}};
      default: return 32'($urandom_range(8)) - 32'd4;
    endcase
  endfunction

  // Near-rotation: random signed permutation of identity plus small noise.
  function automatic mat_t rnd_rot();
    mat_t m;
    int perm[3];
    perm = '{0, 1, 2};
    perm.shuffle();
    for (int i = 0; i < NUM_ELEMS; i++) m[i] = 32'($urandom_range(4095)) - 32'd2048;
    for (int r = 0; r < 3; r++) m[r*3 + perm[r]] += ($urandom_range(1) ? P1 : N1);
    return m;
  endfunction

  initial begin
    dir_row_t dir[$];
    mat_t m;
    int k;
    // identity: trace pivot, w = 1
    dir.push_back('{'{P1, 0, 0, 0, P1, 0, 0, 0, P1}, 1, '{31'h4000_0000, 0, 0, 0, 0}});
    // pi about x, y, z: each non-trace pivot gives one unit component
    dir.push_back('{'{P1, 0, 0, 0, N1, 0, 0, 0, N1}, 1, '{0, P1, 0, 0, 0}});
    dir.push_back('{'{N1, 0, 0, 0, P1, 0, 0, 0, N1}, 1, '{0, 0, P1, 0, 0}});
    dir.push_back('{'{N1, 0, 0, 0, N1, 0, 0, 0, P1}, 1, '{0, 0, 0, P1, 0}});
    // all zero: x pivot with a radicand of one, unit x
    dir.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, P1, 0, 0, 0}});
    // negated identity: x pivot with a radicand of two, unit x
    dir.push_back('{'{N1, 0, 0, 0, N1, 0, 0, 0, N1}, 1, '{0, P1, 0, 0, 0}});
    // extremes and mixed patterns, checked by the model
    dir.push_back('{'{MX, MX, MX, MX, MX, MX, MX, MX, MX}, 0, '0});
    dir.push_back('{'{MN, MN, MN, MN, MN, MN, MN, MN, MN}, 0, '0});
    dir.push_back('{'{MX, MN, MX, MN, MX, MN, MX, MN, MX}, 0, '0});
    dir.push_back('{'{MN, MX, MN, MX, MN, MX, MN, MX, MN}, 0, '0});
    dir.push_back('{'{'1, '1, '1, '1, '1, '1, '1, '1, '1}, 0, '0});
    // mixed signs under the trace pivot, and w exactly zero
    dir.push_back('{'{P1, N1, P1, P1, P1, N1, N1, P1, P1}, 0, '0});
    dir.push_back('{'{N1, P1, 0, P1, N1, 0, 0, 0, P1}, 0, '0});
    dir.push_back('{'{0, MX, MN, MN, 0, MX, MX, MN, 0}, 0, '0});
    // ties on the diagonal exercise the strict compares
    dir.push_back('{'{0, 5, 7, 3, 0, 9, 1, 2, 0}, 0, '0});
    dir.push_back('{'{N1, 5, 7, 3, 0, 9, 1, 2, 0}, 0, '0});
    dir.push_back('{'{N1, 5, 7, 3, N1, 9, 1, 2, N1}, 0, '0});
    // rounding/saturation of the truncated norm
    dir.push_back('{'{1, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '0});
    dir.push_back('{'{P1, 1, 0, 0, P1, 1, 0, 0, P1}, 0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 10; recv_idle = 50;
    foreach (dir[i]) send_matrix(dir[i].m, dir[i].chk, dir[i].want);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 50; recv_idle = 10; end
      if (ph == 2) begin send_idle = 0;  recv_idle = 0;  end
      for (k = 0; k < 470; k++) begin
        if ($urandom_range(9) < 7) m = rnd_rot();
        else for (int i = 0; i < NUM_ELEMS; i++) m[i] = rnd_elem();
        send_matrix(m, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;
    wait (quat_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("dcm_to_unit_quaternion test passed");
    else $display("dcm_to_unit_quaternion test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("dcm_to_unit_quaternion test failed");
    $finish;
  end
endmodule
